// ===== design/lrcg_pkg.sv =====
package lrcg_pkg;

  localparam logic [1:0] CFG_MOTION_X = 2'd0;
  localparam logic [1:0] CFG_MOTION_Y = 2'd1;
  localparam logic [1:0] CFG_MOTION_Z = 2'd2;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;

  typedef enum logic [1:0] {
    IK_HEADER,
    IK_POINT,
    IK_SKIP
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic               last;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic signed [31:0] qu;
    logic signed [31:0] qv;
    logic [30:0]        sigma;
  } item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } motion_t;

  typedef struct packed {
    logic signed [31:0] cost;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] gz;
  } result_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_HDR,
    ST_D0, ST_D1, ST_D2, ST_D3,
    ST_H0, ST_H1, ST_H2, ST_H3,
    ST_RX_GO, ST_RX_WAIT, ST_RY_GO, ST_RY_WAIT,
    ST_Z1A, ST_Z1B, ST_Z1C, ST_Z2A, ST_Z2B, ST_Z2C,
    ST_R2A, ST_R2B, ST_R2C,
    ST_CX_GO, ST_CX_WAIT, ST_LNORM,
    ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7, ST_L8,
    ST_DENA, ST_DENB, ST_DENC, ST_DEND,
    ST_W1A, ST_W1B, ST_W1GO, ST_W1WAIT,
    ST_W2A, ST_W2B, ST_W2GO, ST_W2WAIT,
    ST_G0, ST_G1, ST_G2, ST_G3,
    ST_EMIT
  } st_t;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'sd140737488355327) r = 48'sh7fffffffffff;
    else if (v < -64'sd140737488355328) r = 48'sh800000000000;
    else r = v[47:0];
    return r;
  endfunction

  // log2 of a Q30 mantissa in [1,2) by repeated squaring; constant use only
  function automatic logic [63:0] log2_squares(logic [63:0] m0);
    logic [63:0] m;
    logic [63:0] r;
    m = m0;
    r = '0;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= 2 * ONE_Q30) begin
        m = m >> 1;
        r = r | (64'd1 << b);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/lrcg_front.sv =====
module lrcg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic signed [31:0] in_vec_a_x,
  input  logic signed [31:0] in_vec_a_y,
  input  logic signed [31:0] in_vec_a_z,
  input  logic signed [31:0] in_fixed_x,
  input  logic signed [31:0] in_fixed_y,
  input  logic signed [31:0] in_fixed_z,
  input  logic signed [31:0] in_image_u,
  input  logic signed [31:0] in_image_v,
  input  logic [30:0]        in_sigma_in,
  input  logic               in_point_valid,
  input  logic               in_seg_last,
  output lrcg_pkg::item_t    head,
  output logic               head_valid,
  input  logic               head_pop
);

  lrcg_pkg::item_t q_r [2];
  lrcg_pkg::item_t item;
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push_ok, pop_ok;

  always_comb begin
    item.kind  = !in_func ? lrcg_pkg::IK_HEADER :
                 (in_point_valid ? lrcg_pkg::IK_POINT : lrcg_pkg::IK_SKIP);
    item.last  = in_seg_last;
    item.ax    = in_vec_a_x;
    item.ay    = in_vec_a_y;
    item.az    = in_vec_a_z;
    item.fx    = in_fixed_x;
    item.fy    = in_fixed_y;
    item.fz    = in_fixed_z;
    item.qu    = in_image_u;
    item.qv    = in_image_v;
    item.sigma = in_sigma_in;
  end

  assign in_full    = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + 2'(push_ok) - 2'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= item;
  end

endmodule

// ===== design/lrcg_div.sv =====
module lrcg_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lrcg_pkg::div_req_t req,
  output lrcg_pkg::div_rsp_t rsp
);

  localparam int QW = 33 + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);
  localparam int RW = 34;

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [RW-1:0]   rem_r;
  logic [QW-1:0]   dvd_r;
  logic [32:0]     nb_r;
  logic            neg_r;
  logic            done_r;
  logic signed [31:0] quo_r;

  logic signed [32:0] nx, dx;
  logic [32:0]     na, nb;
  logic [RW-1:0]   rem_sh;
  logic            ge;

  always_comb begin
    nx     = 33'(req.num);
    dx     = 33'(req.den);
    na     = nx[32] ? 33'(-nx) : 33'(nx);
    nb     = dx[32] ? 33'(-dx) : 33'(dx);
    rem_sh = {rem_r[RW-2:0], dvd_r[QW-1]};
    ge     = (rem_sh >= {1'b0, nb_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && req.start) begin
        if (req.den == 32'sd0) begin
          quo_r  <= req.num[31] ? 32'sh80000000 : 32'sh7fffffff;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        if (!neg_r)
          quo_r <= (dvd_r > QW'(64'h7fffffff)) ? 32'sh7fffffff : dvd_r[31:0];
        else
          quo_r <= (dvd_r > QW'(64'h80000000)) ? 32'sh80000000 : 32'(-dvd_r[31:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      rem_r <= '0;
      dvd_r <= QW'(na) << FRAC_BITS;
      nb_r  <= nb;
      neg_r <= req.num[31] ^ req.den[31];
      cnt_r <= CW'(QW);
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge ? rem_sh - {1'b0, nb_r} : rem_sh;
      dvd_r <= {dvd_r[QW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ===== design/lrcg_back.sv =====
module lrcg_back #(
  parameter int FRAC_BITS       = 16,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lrcg_pkg::item_t   head,
  input  logic              head_valid,
  output logic              head_pop,
  input  lrcg_pkg::motion_t motion,
  output lrcg_pkg::result_t res,
  output logic              res_valid,
  input  logic              res_pop
);

  localparam int TIW = $clog2(LOG_TABLE_DEPTH + 1);
  localparam logic [32:0] ONE_Y = 33'd1 << FRAC_BITS;

  lrcg_pkg::st_t      state_r, state_nxt;
  lrcg_pkg::item_t    cur_r;
  lrcg_pkg::div_req_t div_req;
  lrcg_pkg::div_rsp_t div_rsp;
  lrcg_pkg::result_t  res_r;
  logic               res_valid_r;

  logic signed [31:0] n0_r, n1_r, n2_r;
  logic [30:0]        sigma_r;
  logic signed [47:0] cost_r, g0_r, g1_r, g2_r;
  logic signed [33:0] acc_r;
  logic signed [31:0] d_r, hx_r, hy_r, hz_r, rx_r, ry_r, z1_r, z2_r;
  logic signed [31:0] hr2_r, den_r, w_r;
  logic [32:0]        lny_r;
  logic [5:0]         k_r;
  logic [TIW-1:0]     idx_r, tab_addr;
  logic [29:0]        rem_r;
  logic [30:0]        tab_r, lo_r, interp_r, lnf_r;

  logic signed [31:0] mul_a, mul_b, qm, sps, r2;
  logic signed [63:0] prod_r;
  logic [36:0]        lnq, ln_q;

  logic [30:0] log_tab [LOG_TABLE_DEPTH+1];

  for (genvar g = 0; g < LOG_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] M0 = lrcg_pkg::ONE_Q30 +
                                 ((64'(g) << 30) / LOG_TABLE_DEPTH);
    assign log_tab[g] = 31'(lrcg_pkg::log2_squares(M0));
  end
  assign log_tab[LOG_TABLE_DEPTH] = 31'(lrcg_pkg::ONE_Q30);

  lrcg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign qm   = lrcg_pkg::sat32(prod_r >>> FRAC_BITS);
  assign sps  = lrcg_pkg::sat32(64'({1'b0, sigma_r}) + 64'(hr2_r));
  assign r2   = lrcg_pkg::sat32(64'(acc_r) + 64'(qm));
  assign lnq  = 37'(prod_r[35:0]) + 37'(lnf_r);
  assign ln_q = lnq >> (30 - FRAC_BITS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrcg_pkg::ST_IDLE:
        if (head_valid) begin
          unique case (head.kind)
            lrcg_pkg::IK_HEADER: state_nxt = lrcg_pkg::ST_HDR;
            lrcg_pkg::IK_POINT:  state_nxt = lrcg_pkg::ST_D0;
            default: state_nxt = head.last ? lrcg_pkg::ST_EMIT : lrcg_pkg::ST_IDLE;
          endcase
        end
      lrcg_pkg::ST_HDR:  state_nxt = cur_r.last ? lrcg_pkg::ST_EMIT : lrcg_pkg::ST_IDLE;
      lrcg_pkg::ST_D0:   state_nxt = lrcg_pkg::ST_D1;
      lrcg_pkg::ST_D1:   state_nxt = lrcg_pkg::ST_D2;
      lrcg_pkg::ST_D2:   state_nxt = lrcg_pkg::ST_D3;
      lrcg_pkg::ST_D3:   state_nxt = lrcg_pkg::ST_H0;
      lrcg_pkg::ST_H0:   state_nxt = lrcg_pkg::ST_H1;
      lrcg_pkg::ST_H1:   state_nxt = lrcg_pkg::ST_H2;
      lrcg_pkg::ST_H2:   state_nxt = lrcg_pkg::ST_H3;
      lrcg_pkg::ST_H3:   state_nxt = lrcg_pkg::ST_RX_GO;
      lrcg_pkg::ST_RX_GO: state_nxt = lrcg_pkg::ST_RX_WAIT;
      lrcg_pkg::ST_RX_WAIT: if (div_rsp.done) state_nxt = lrcg_pkg::ST_RY_GO;
      lrcg_pkg::ST_RY_GO: state_nxt = lrcg_pkg::ST_RY_WAIT;
      lrcg_pkg::ST_RY_WAIT: if (div_rsp.done) state_nxt = lrcg_pkg::ST_Z1A;
      lrcg_pkg::ST_Z1A:  state_nxt = lrcg_pkg::ST_Z1B;
      lrcg_pkg::ST_Z1B:  state_nxt = lrcg_pkg::ST_Z1C;
      lrcg_pkg::ST_Z1C:  state_nxt = lrcg_pkg::ST_Z2A;
      lrcg_pkg::ST_Z2A:  state_nxt = lrcg_pkg::ST_Z2B;
      lrcg_pkg::ST_Z2B:  state_nxt = lrcg_pkg::ST_Z2C;
      lrcg_pkg::ST_Z2C:  state_nxt = lrcg_pkg::ST_R2A;
      lrcg_pkg::ST_R2A:  state_nxt = lrcg_pkg::ST_R2B;
      lrcg_pkg::ST_R2B:  state_nxt = lrcg_pkg::ST_R2C;
      lrcg_pkg::ST_R2C:  state_nxt = lrcg_pkg::ST_CX_GO;
      lrcg_pkg::ST_CX_GO: state_nxt = lrcg_pkg::ST_CX_WAIT;
      lrcg_pkg::ST_CX_WAIT: if (div_rsp.done) state_nxt = lrcg_pkg::ST_LNORM;
      lrcg_pkg::ST_LNORM: if (lny_r[32]) state_nxt = lrcg_pkg::ST_L1;
      lrcg_pkg::ST_L1:   state_nxt = lrcg_pkg::ST_L2;
      lrcg_pkg::ST_L2:   state_nxt = lrcg_pkg::ST_L3;
      lrcg_pkg::ST_L3:   state_nxt = lrcg_pkg::ST_L4;
      lrcg_pkg::ST_L4:   state_nxt = lrcg_pkg::ST_L5;
      lrcg_pkg::ST_L5:   state_nxt = lrcg_pkg::ST_L6;
      lrcg_pkg::ST_L6:   state_nxt = lrcg_pkg::ST_L7;
      lrcg_pkg::ST_L7:   state_nxt = lrcg_pkg::ST_L8;
      lrcg_pkg::ST_L8:   state_nxt = lrcg_pkg::ST_DENA;
      lrcg_pkg::ST_DENA: state_nxt = lrcg_pkg::ST_DENB;
      lrcg_pkg::ST_DENB: state_nxt = lrcg_pkg::ST_DENC;
      lrcg_pkg::ST_DENC: state_nxt = lrcg_pkg::ST_DEND;
      lrcg_pkg::ST_DEND: state_nxt = lrcg_pkg::ST_W1A;
      lrcg_pkg::ST_W1A:  state_nxt = lrcg_pkg::ST_W1B;
      lrcg_pkg::ST_W1B:  state_nxt = lrcg_pkg::ST_W1GO;
      lrcg_pkg::ST_W1GO: state_nxt = lrcg_pkg::ST_W1WAIT;
      lrcg_pkg::ST_W1WAIT: if (div_rsp.done) state_nxt = lrcg_pkg::ST_W2A;
      lrcg_pkg::ST_W2A:  state_nxt = lrcg_pkg::ST_W2B;
      lrcg_pkg::ST_W2B:  state_nxt = lrcg_pkg::ST_W2GO;
      lrcg_pkg::ST_W2GO: state_nxt = lrcg_pkg::ST_W2WAIT;
      lrcg_pkg::ST_W2WAIT: if (div_rsp.done) state_nxt = lrcg_pkg::ST_G0;
      lrcg_pkg::ST_G0:   state_nxt = lrcg_pkg::ST_G1;
      lrcg_pkg::ST_G1:   state_nxt = lrcg_pkg::ST_G2;
      lrcg_pkg::ST_G2:   state_nxt = lrcg_pkg::ST_G3;
      lrcg_pkg::ST_G3:   state_nxt = cur_r.last ? lrcg_pkg::ST_EMIT : lrcg_pkg::ST_IDLE;
      lrcg_pkg::ST_EMIT: if (!res_valid_r) state_nxt = lrcg_pkg::ST_IDLE;
      default:           state_nxt = lrcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_pop = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    div_req  = '0;
    tab_addr = idx_r;
    unique case (state_r)
      lrcg_pkg::ST_IDLE:  head_pop = head_valid;
      lrcg_pkg::ST_D0:    begin mul_a = n0_r; mul_b = cur_r.ax; end
      lrcg_pkg::ST_D1:    begin mul_a = n1_r; mul_b = cur_r.ay; end
      lrcg_pkg::ST_D2:    begin mul_a = n2_r; mul_b = cur_r.az; end
      lrcg_pkg::ST_H0:    begin mul_a = motion.x; mul_b = d_r; end
      lrcg_pkg::ST_H1:    begin mul_a = motion.y; mul_b = d_r; end
      lrcg_pkg::ST_H2:    begin mul_a = motion.z; mul_b = d_r; end
      lrcg_pkg::ST_RX_GO: begin div_req.start = 1'b1; div_req.num = hx_r; div_req.den = hz_r; end
      lrcg_pkg::ST_RY_GO: begin div_req.start = 1'b1; div_req.num = hy_r; div_req.den = hz_r; end
      lrcg_pkg::ST_Z1A:   begin mul_a = motion.x; mul_b = hz_r; end
      lrcg_pkg::ST_Z1B:   begin mul_a = hx_r; mul_b = motion.z; end
      lrcg_pkg::ST_Z2A:   begin mul_a = motion.y; mul_b = hz_r; end
      lrcg_pkg::ST_Z2B:   begin mul_a = hy_r; mul_b = motion.z; end
      lrcg_pkg::ST_R2A:   begin mul_a = rx_r; mul_b = rx_r; end
      lrcg_pkg::ST_R2B:   begin mul_a = ry_r; mul_b = ry_r; end
      lrcg_pkg::ST_CX_GO: begin
        div_req.start = 1'b1;
        div_req.num   = hr2_r;
        div_req.den   = {1'b0, sigma_r};
      end
      lrcg_pkg::ST_L1:    begin mul_a = {2'b0, lny_r[31:2]}; mul_b = 32'(LOG_TABLE_DEPTH); end
      lrcg_pkg::ST_L2:    tab_addr = prod_r[30 +: TIW];
      lrcg_pkg::ST_L3:    tab_addr = idx_r + TIW'(1);
      lrcg_pkg::ST_L4:    begin mul_a = 32'(tab_r) - 32'(lo_r); mul_b = {2'b0, rem_r}; end
      lrcg_pkg::ST_L6:    begin mul_a = {1'b0, interp_r}; mul_b = lrcg_pkg::LN2_Q30; end
      lrcg_pkg::ST_L7:    begin mul_a = 32'(k_r - 6'(FRAC_BITS)); mul_b = lrcg_pkg::LN2_Q30; end
      lrcg_pkg::ST_DENA:  begin mul_a = hz_r; mul_b = hz_r; end
      lrcg_pkg::ST_DENC:  begin mul_a = acc_r[31:0]; mul_b = sps; end
      lrcg_pkg::ST_W1A:   begin mul_a = rx_r; mul_b = z1_r; end
      lrcg_pkg::ST_W1GO:  begin div_req.start = 1'b1; div_req.num = acc_r[31:0]; div_req.den = den_r; end
      lrcg_pkg::ST_W2A:   begin mul_a = ry_r; mul_b = z2_r; end
      lrcg_pkg::ST_W2GO:  begin div_req.start = 1'b1; div_req.num = acc_r[31:0]; div_req.den = den_r; end
      lrcg_pkg::ST_G0:    begin mul_a = cur_r.ax; mul_b = w_r; end
      lrcg_pkg::ST_G1:    begin mul_a = cur_r.ay; mul_b = w_r; end
      lrcg_pkg::ST_G2:    begin mul_a = cur_r.az; mul_b = w_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= lrcg_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    tab_r  <= log_tab[tab_addr];
    if (head_pop) cur_r <= head;
    unique case (state_r)
      lrcg_pkg::ST_D1:   acc_r <= 34'(qm);
      lrcg_pkg::ST_D2:   acc_r <= acc_r + 34'(qm);
      lrcg_pkg::ST_D3:   d_r <= lrcg_pkg::sat32(64'(acc_r) + 64'(qm));
      lrcg_pkg::ST_H1:   hx_r <= lrcg_pkg::sat32(64'(cur_r.fx) - 64'(qm));
      lrcg_pkg::ST_H2:   hy_r <= lrcg_pkg::sat32(64'(cur_r.fy) - 64'(qm));
      lrcg_pkg::ST_H3:   hz_r <= lrcg_pkg::sat32(64'(cur_r.fz) - 64'(qm));
      lrcg_pkg::ST_RX_WAIT:
        if (div_rsp.done) rx_r <= lrcg_pkg::sat32(64'(cur_r.qu) - 64'(div_rsp.quo));
      lrcg_pkg::ST_RY_WAIT:
        if (div_rsp.done) ry_r <= lrcg_pkg::sat32(64'(cur_r.qv) - 64'(div_rsp.quo));
      lrcg_pkg::ST_Z1B, lrcg_pkg::ST_Z2B, lrcg_pkg::ST_R2B,
      lrcg_pkg::ST_DENB, lrcg_pkg::ST_W1B, lrcg_pkg::ST_W2B:
        acc_r <= 34'(qm);
      lrcg_pkg::ST_Z1C:  z1_r <= lrcg_pkg::sat32(64'(acc_r) - 64'(qm));
      lrcg_pkg::ST_Z2C:  z2_r <= lrcg_pkg::sat32(64'(acc_r) - 64'(qm));
      lrcg_pkg::ST_R2C:  hr2_r <= r2 >>> 1;  // r2 is never negative
      lrcg_pkg::ST_CX_WAIT:
        if (div_rsp.done) begin
          lny_r <= ONE_Y + {1'b0, div_rsp.quo};
          k_r   <= 6'd32;
        end
      lrcg_pkg::ST_LNORM:
        if (!lny_r[32]) begin
          lny_r <= {lny_r[31:0], 1'b0};
          k_r   <= k_r - 6'd1;
        end
      lrcg_pkg::ST_L2: begin
        idx_r <= prod_r[30 +: TIW];
        rem_r <= prod_r[29:0];
      end
      lrcg_pkg::ST_L3:   lo_r <= tab_r;
      lrcg_pkg::ST_L5:   interp_r <= lo_r + prod_r[60:30];
      lrcg_pkg::ST_L7:   lnf_r <= prod_r[60:30];
      lrcg_pkg::ST_DEND: den_r <= qm;
      lrcg_pkg::ST_W1WAIT: if (div_rsp.done) w_r <= div_rsp.quo;
      lrcg_pkg::ST_W2WAIT:
        if (div_rsp.done) w_r <= lrcg_pkg::sat32(64'(w_r) + 64'(div_rsp.quo));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_r        <= '0;
      n1_r        <= '0;
      n2_r        <= '0;
      sigma_r     <= 31'd1 << FRAC_BITS;
      cost_r      <= '0;
      g0_r        <= '0;
      g1_r        <= '0;
      g2_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (res_pop && res_valid_r) res_valid_r <= 1'b0;
      unique case (state_r)
        lrcg_pkg::ST_HDR: begin
          n0_r    <= cur_r.ax;
          n1_r    <= cur_r.ay;
          n2_r    <= cur_r.az;
          sigma_r <= cur_r.sigma;
          cost_r  <= '0;
          g0_r    <= '0;
          g1_r    <= '0;
          g2_r    <= '0;
        end
        lrcg_pkg::ST_L8: cost_r <= lrcg_pkg::sat48(64'(cost_r) + signed'(64'(ln_q)));
        lrcg_pkg::ST_G1: g0_r <= lrcg_pkg::sat48(64'(g0_r) + 64'(qm));
        lrcg_pkg::ST_G2: g1_r <= lrcg_pkg::sat48(64'(g1_r) + 64'(qm));
        lrcg_pkg::ST_G3: g2_r <= lrcg_pkg::sat48(64'(g2_r) + 64'(qm));
        lrcg_pkg::ST_EMIT:
          if (!res_valid_r) begin
            res_valid_r <= 1'b1;
            res_r.cost  <= lrcg_pkg::sat32(64'(cost_r));
            res_r.gx    <= lrcg_pkg::sat32(64'(g0_r));
            res_r.gy    <= lrcg_pkg::sat32(64'(g1_r));
            res_r.gz    <= lrcg_pkg::sat32(64'(g2_r));
            cost_r      <= '0;
            g0_r        <= '0;
            g1_r        <= '0;
            g2_r        <= '0;
          end
        default: ;
      endcase
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

// ===== design/lorentzian_reprojection_cost_grad.sv =====
// Point time: a valid point's time is set by five passes through the bit-serial
//   divider and the leading-one walk of the log unit; a last item then goes on to emit.
// Throughput: one item at a time in the back end; two items queue in front of it.
// Reset: synchronous, active low; clears queue, sums, normal, motion; sigma = 1.0.
module lorentzian_reprojection_cost_grad #(
  parameter int FRAC_BITS       = 16,
  parameter int LOG_TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_func,
  input  logic signed [31:0] in_vec_a_x,
  input  logic signed [31:0] in_vec_a_y,
  input  logic signed [31:0] in_vec_a_z,
  input  logic signed [31:0] in_fixed_x,
  input  logic signed [31:0] in_fixed_y,
  input  logic signed [31:0] in_fixed_z,
  input  logic signed [31:0] in_image_u,
  input  logic signed [31:0] in_image_v,
  input  logic [30:0]        in_sigma_in,
  input  logic               in_point_valid,
  input  logic               in_seg_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_seg_cost,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  lrcg_pkg::item_t   head;
  logic              head_valid, head_pop;
  lrcg_pkg::motion_t motion_r;
  lrcg_pkg::result_t res;
  logic              res_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrcg_pkg::CFG_MOTION_X: motion_r.x <= cfg_data;
        lrcg_pkg::CFG_MOTION_Y: motion_r.y <= cfg_data;
        lrcg_pkg::CFG_MOTION_Z: motion_r.z <= cfg_data;
        default: ;
      endcase
    end
  end

  lrcg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_vec_a_x    (in_vec_a_x),
    .in_vec_a_y    (in_vec_a_y),
    .in_vec_a_z    (in_vec_a_z),
    .in_fixed_x    (in_fixed_x),
    .in_fixed_y    (in_fixed_y),
    .in_fixed_z    (in_fixed_z),
    .in_image_u    (in_image_u),
    .in_image_v    (in_image_v),
    .in_sigma_in   (in_sigma_in),
    .in_point_valid(in_point_valid),
    .in_seg_last   (in_seg_last),
    .head          (head),
    .head_valid    (head_valid),
    .head_pop      (head_pop)
  );

  lrcg_back #(
    .FRAC_BITS      (FRAC_BITS),
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(head_valid),
    .head_pop  (head_pop),
    .motion    (motion_r),
    .res       (res),
    .res_valid (res_valid),
    .res_pop   (out_pop)
  );

  assign out_empty    = !res_valid;
  assign out_seg_cost = res.cost;
  assign out_grad_x   = res.gx;
  assign out_grad_y   = res.gy;
  assign out_grad_z   = res.gz;

endmodule

// ===== design/lrcg_checker.sv =====
module lrcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_seg_cost,
  input logic [31:0] out_grad_x,
  input logic [31:0] out_grad_y,
  input logic [31:0] out_grad_z,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_seg_cost) && $stable(out_grad_x) &&
                                 $stable(out_grad_y) && $stable(out_grad_z)))
    else $error("result changed while waiting");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("queue full after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config request refused");

endmodule

bind lorentzian_reprojection_cost_grad lrcg_checker u_chk (.*);
